// File: src/crop_window_with_taken_map_macros.svh
// ----------------------------------------------------------------------------
// Crop window assertion macros
// Shared helpers for the concurrent checks of the crop window block.
// ----------------------------------------------------------------------------
`ifndef CROP_WINDOW_WITH_TAKEN_MAP_MACROS_SVH
`define CROP_WINDOW_WITH_TAKEN_MAP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CWTM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("crop window check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CWTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("crop window check failed");

`endif

// File: src/cwtm_pkg.sv
// ----------------------------------------------------------------------------
// Crop window package
// Constants, codes and stage types of the crop window block.
// ----------------------------------------------------------------------------
`default_nettype none

package cwtm_pkg;

  localparam int unsigned MaxImgWDefault = 256;
  localparam int unsigned MaxImgHDefault = 256;

  // The taken map is stored as words of bits; one word is cleared per cycle.
  localparam int unsigned MapWordW = 32;
  localparam int unsigned MapBitW  = 5;

  localparam int unsigned PaddrW = 5;
  localparam int unsigned PdataW = 32;

  // Register indexes.
  localparam logic [2:0] RegImgWidth     = 3'd0;
  localparam logic [2:0] RegImgHeight    = 3'd1;
  localparam logic [2:0] RegChannelCount = 3'd2;
  localparam logic [2:0] RegDedupeEnable = 3'd3;
  localparam logic [2:0] RegWinXMin      = 3'd4;
  localparam logic [2:0] RegWinYMin      = 3'd5;
  localparam logic [2:0] RegWinWidth     = 3'd6;
  localparam logic [2:0] RegWinHeight    = 3'd7;

  // Result status codes.
  localparam logic [1:0] StatCopied    = 2'd0;
  localparam logic [1:0] StatOutImage  = 2'd1;
  localparam logic [1:0] StatTaken     = 2'd2;
  localparam logic [1:0] StatOutWindow = 2'd3;

  // Item held between the map read and the map write back.
  typedef struct packed {
    logic [17:0]        dest;
    logic [31:0]        pixel;
    logic               last;
    logic               in_win;
    logic               in_img;
    logic [MapBitW-1:0] bsel;
  } stage_t;

endpackage

`default_nettype wire

// File: src/crop_window_with_taken_map.sv
// An accepted item passes through the stage register s1_q and the output register.
// Throughput: one item per cycle unless the output stalls or the map is cleared;
// the taken map read-modify-write is forwarded. The taken map is one synchronous
// memory of 32-bit words with a single write port. After reset a clearing pass
// zeroes it, one word per cycle, while in_ready_o stays low.
// Registers reset to their documented values; register writes are taken at any time.
// ----------------------------------------------------------------------------
// Crop window with taken map
// Maps visited source positions into a crop window, pads outside the image
// with zero and optionally hands each source pixel out only once.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crop_window_with_taken_map_macros.svh"

module crop_window_with_taken_map #(
  parameter int unsigned MAX_IMG_W = cwtm_pkg::MaxImgWDefault,
  parameter int unsigned MAX_IMG_H = cwtm_pkg::MaxImgHDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Configuration port.
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cwtm_pkg::PaddrW-1:0] paddr,
  input  wire logic [cwtm_pkg::PdataW-1:0] pwdata,
  output logic      [cwtm_pkg::PdataW-1:0] prdata,
  output logic                             pready,
  // Input channel.
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic signed [11:0]          pos_x_i,
  input  wire logic signed [11:0]          pos_y_i,
  input  wire logic [31:0]                 src_pixel_i,
  // Output channel.
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [17:0]                      dest_index_o,
  output logic [31:0]                      out_pixel_o,
  output logic [1:0]                       status_o,
  output logic                             last_o
);

  localparam int unsigned MapSize  = MAX_IMG_W * MAX_IMG_H;
  localparam int unsigned MapDepth = (MapSize + cwtm_pkg::MapWordW - 1) / cwtm_pkg::MapWordW;
  localparam int unsigned MapAddrW = (MapDepth > 1) ? $clog2(MapDepth) : 1;
  localparam int unsigned IdxW     = MapAddrW + cwtm_pkg::MapBitW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [8:0]         img_width_q, img_height_q;
  logic [2:0]         channel_count_q;
  logic               dedupe_enable_q;
  logic signed [11:0] win_x_min_q, win_y_min_q;
  logic [9:0]         win_width_q, win_height_q;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[cwtm_pkg::PaddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q     <= 9'd256;
      img_height_q    <= 9'd256;
      channel_count_q <= 3'd4;
      dedupe_enable_q <= 1'b0;
      win_x_min_q     <= '0;
      win_y_min_q     <= '0;
      win_width_q     <= 10'd1;
      win_height_q    <= 10'd1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        cwtm_pkg::RegImgWidth:     img_width_q     <= pwdata[8:0];
        cwtm_pkg::RegImgHeight:    img_height_q    <= pwdata[8:0];
        cwtm_pkg::RegChannelCount: channel_count_q <= pwdata[2:0];
        cwtm_pkg::RegDedupeEnable: dedupe_enable_q <= pwdata[0];
        cwtm_pkg::RegWinXMin:      win_x_min_q     <= pwdata[11:0];
        cwtm_pkg::RegWinYMin:      win_y_min_q     <= pwdata[11:0];
        cwtm_pkg::RegWinWidth:     win_width_q     <= pwdata[9:0];
        cwtm_pkg::RegWinHeight:    win_height_q    <= pwdata[9:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      cwtm_pkg::RegImgWidth:     prdata = 32'(img_width_q);
      cwtm_pkg::RegImgHeight:    prdata = 32'(img_height_q);
      cwtm_pkg::RegChannelCount: prdata = 32'(channel_count_q);
      cwtm_pkg::RegDedupeEnable: prdata = 32'(dedupe_enable_q);
      cwtm_pkg::RegWinXMin:      prdata = 32'(unsigned'(win_x_min_q));
      cwtm_pkg::RegWinYMin:      prdata = 32'(unsigned'(win_y_min_q));
      cwtm_pkg::RegWinWidth:     prdata = 32'(win_width_q);
      cwtm_pkg::RegWinHeight:    prdata = 32'(win_height_q);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------------
  logic                  clr_busy_q;
  logic [MapAddrW-1:0]   clr_addr_q;
  logic                  s1_vld_q, out_vld_q;
  logic                  s1_adv, in_acc;
  cwtm_pkg::stage_t      s1_q, s1_d;
  logic [MapAddrW-1:0]   s1_addr_q;

  assign s1_adv     = !out_vld_q || out_ready_i;
  assign in_ready_o = !clr_busy_q && (!s1_vld_q || s1_adv);
  assign in_acc     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Address and window arithmetic ahead of the map read
  // ---------------------------------------------------------------------------
  logic [8:0]         eff_w, eff_h;
  logic signed [12:0] dx, dy;
  logic               x_in_win, y_in_win, x_in_img, y_in_img;
  logic [19:0]        win_prod, img_prod;
  logic [20:0]        idx_sum;
  logic [IdxW-1:0]    map_idx;
  logic [31:0]        ch_mask;

  // Saturate the image size to the map dimensions.
  assign eff_w = ({4'b0, img_width_q} > 13'(MAX_IMG_W))  ? 9'(MAX_IMG_W) : img_width_q;
  assign eff_h = ({4'b0, img_height_q} > 13'(MAX_IMG_H)) ? 9'(MAX_IMG_H) : img_height_q;

  assign dx = 13'({pos_x_i[11], pos_x_i}) - 13'({win_x_min_q[11], win_x_min_q});
  assign dy = 13'({pos_y_i[11], pos_y_i}) - 13'({win_y_min_q[11], win_y_min_q});

  assign x_in_win = !dx[12] && (dx[11:0] < {2'b0, win_width_q});
  assign y_in_win = !dy[12] && (dy[11:0] < {2'b0, win_height_q});
  assign x_in_img = !pos_x_i[11] && ({1'b0, pos_x_i[10:0]} < {3'b0, eff_w});
  assign y_in_img = !pos_y_i[11] && ({1'b0, pos_y_i[10:0]} < {3'b0, eff_h});

  assign win_prod = 20'(dy[9:0]) * 20'(win_width_q);
  assign img_prod = 20'(pos_y_i[10:0]) * 20'(eff_w);
  assign idx_sum  = 21'(img_prod) + 21'(pos_x_i[10:0]);
  assign map_idx  = IdxW'(idx_sum);

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      ch_mask[8*b +: 8] = {8{channel_count_q > 3'(b)}};
    end
  end

  always_comb begin
    s1_d.dest   = 18'(win_prod + 20'(dx[9:0]));
    s1_d.pixel  = src_pixel_i & ch_mask;
    s1_d.last   = (11'(dx[9:0]) + 11'd1 == {1'b0, win_width_q}) &&
                  (11'(dy[9:0]) + 11'd1 == {1'b0, win_height_q});
    s1_d.in_win = x_in_win && y_in_win;
    s1_d.in_img = x_in_img && y_in_img;
    s1_d.bsel   = map_idx[cwtm_pkg::MapBitW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q      <= s1_d;
      s1_addr_q <= map_idx[IdxW-1:cwtm_pkg::MapBitW];
    end
  end

  // ---------------------------------------------------------------------------
  // Taken map memory with clearing pass
  // ---------------------------------------------------------------------------
  logic [cwtm_pkg::MapWordW-1:0] taken_mem [MapDepth];
  logic [cwtm_pkg::MapWordW-1:0] rdata_q;
  logic                          mem_we;
  logic [MapAddrW-1:0]           mem_waddr;
  logic [cwtm_pkg::MapWordW-1:0] mem_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == MapAddrW'(MapDepth - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      taken_mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rdata_q <= taken_mem[map_idx[IdxW-1:cwtm_pkg::MapBitW]];
    end
  end

  // ---------------------------------------------------------------------------
  // Read-modify-write with forwarding of the most recent write back
  // ---------------------------------------------------------------------------
  logic                          wr_vld_q;
  logic [MapAddrW-1:0]           wr_addr_q;
  logic [cwtm_pkg::MapWordW-1:0] wr_data_q;
  logic [cwtm_pkg::MapWordW-1:0] cur_word, set_word;
  logic                          taken, item_we, s1_move;
  logic [1:0]                    s1_status;

  assign s1_move  = s1_vld_q && s1_adv;
  // The most recent write back may have hit this word as it was read, so the memory
  // may have returned stale data; take the word from the write-back register.
  assign cur_word = (wr_vld_q && wr_addr_q == s1_addr_q) ? wr_data_q : rdata_q;
  assign taken    = cur_word[s1_q.bsel];
  assign set_word = cur_word | (cwtm_pkg::MapWordW'(1) << s1_q.bsel);

  always_comb begin
    priority if (!s1_q.in_win) begin
      s1_status = cwtm_pkg::StatOutWindow;
    end else if (!s1_q.in_img) begin
      s1_status = cwtm_pkg::StatOutImage;
    end else if (dedupe_enable_q && taken) begin
      s1_status = cwtm_pkg::StatTaken;
    end else begin
      s1_status = cwtm_pkg::StatCopied;
    end
  end

  assign item_we = s1_move && dedupe_enable_q && (s1_status == cwtm_pkg::StatCopied);

  assign mem_we    = clr_busy_q || item_we;
  assign mem_waddr = clr_busy_q ? clr_addr_q : s1_addr_q;
  assign mem_wdata = clr_busy_q ? '0 : set_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_vld_q <= 1'b0;
    end else if (item_we) begin
      wr_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_we) begin
      wr_addr_q <= s1_addr_q;
      wr_data_q <= set_word;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      dest_index_o <= s1_q.in_win ? s1_q.dest : '0;
      out_pixel_o  <= (s1_status == cwtm_pkg::StatCopied) ? s1_q.pixel : '0;
      status_o     <= s1_status;
      last_o       <= s1_q.in_win && s1_q.last;
    end
  end

  assign out_valid_o = out_vld_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CWTM_ASSERT_SAME(a_no_accept_in_clear, clk_i, rst_ni, clr_busy_q, !in_ready_o)
  `CWTM_ASSERT_SAME(a_out_window_zero, clk_i, rst_ni,
    out_valid_o && status_o == cwtm_pkg::StatOutWindow,
    dest_index_o == '0 && out_pixel_o == '0 && !last_o)
  `CWTM_ASSERT_SAME(a_taken_zero, clk_i, rst_ni,
    out_valid_o && (status_o == cwtm_pkg::StatTaken || status_o == cwtm_pkg::StatOutImage),
    out_pixel_o == '0)
  `CWTM_ASSERT_NEXT(a_write_forward, clk_i, rst_ni, item_we,
    wr_vld_q && wr_data_q == $past(set_word))

endmodule

`default_nettype wire
